// ----- hdl/sdik_pkg.sv -----
// Package for the swerve drive inverse kinematics block: shared widths,
// register indexes, the wheel transfer record and the CORDIC angle table.
// Depends on nothing; every other file of the block but sdik_fifo uses it.
package sdik_pkg;

   localparam int WHEELS = 4;
   localparam int WHEEL_W = 2;
   localparam int GEO_W = 48;
   localparam int CMD_W = 16;
   localparam int LIMIT_W = 16;
   localparam int SPEED_W = 17;
   localparam int ANGLE_W = 14;
   localparam int CSR_INDEX_W = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int ATAN_ENTRIES = 24;

   localparam logic signed [22:0] HALF_PI_Q20 = 23'sd1647099;
   localparam logic signed [15:0] ANGLE_LIMIT = 16'sd6434;

   localparam logic [GEO_W-1:0] GEOMETRY_A_RESET = 48'd7151241332531;
   localparam logic [GEO_W-1:0] GEOMETRY_B_RESET = 48'd7151241394381;
   localparam logic [GEO_W-1:0] GEOMETRY_C_RESET = 48'd7155294795981;
   localparam logic [GEO_W-1:0] GEOMETRY_D_RESET = 48'd7155294734131;
   localparam logic [LIMIT_W-1:0] MAX_SPEED_RESET = 16'd1289;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GEOMETRY_A = 3'd0,
      CSR_GEOMETRY_B = 3'd1,
      CSR_GEOMETRY_C = 3'd2,
      CSR_GEOMETRY_D = 3'd3,
      CSR_MAX_SPEED  = 3'd4
   } csr_index_type;

   typedef logic [WHEELS-1:0][GEO_W-1:0] geometry_type;

   // One wheel's contact velocity, already folded so that cx is not negative.
   typedef struct packed {
      logic [WHEEL_W-1:0] wheel;
      logic               neg;
      logic [30:0]        cx;
      logic signed [31:0] cy;
   } wheel_item_type;

   function automatic logic [19:0] atan_q20(input logic [4:0] idx);
      logic [19:0] val;
      unique case (idx)
         5'd0:  val = 20'd823550;
         5'd1:  val = 20'd486170;
         5'd2:  val = 20'd256879;
         5'd3:  val = 20'd130396;
         5'd4:  val = 20'd65451;
         5'd5:  val = 20'd32757;
         5'd6:  val = 20'd16383;
         5'd7:  val = 20'd8192;
         5'd8:  val = 20'd4096;
         5'd9:  val = 20'd2048;
         5'd10: val = 20'd1024;
         5'd11: val = 20'd512;
         5'd12: val = 20'd256;
         5'd13: val = 20'd128;
         5'd14: val = 20'd64;
         5'd15: val = 20'd32;
         5'd16: val = 20'd16;
         5'd17: val = 20'd8;
         5'd18: val = 20'd4;
         5'd19: val = 20'd2;
         5'd20: val = 20'd1;
         default: val = 20'd0;
      endcase
      return val;
   endfunction

endpackage

// ----- hdl/sdik_fifo.sv -----
// Small register queue that carries wheel records from the front part to the
// back part. Depends on nothing outside itself.
module sdik_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/sdik_front.sv -----
// Front part: takes a command and forms the folded contact velocity of each
// wheel in turn, one wheel per cycle while the queue has room. Depends on sdik_pkg.
module sdik_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic signed [15:0]          req_linear_x,
   input  logic signed [15:0]          req_linear_y,
   input  logic signed [15:0]          req_angular_z,
   input  sdik_pkg::geometry_type      geometry,
   output logic                        item_push,
   output sdik_pkg::wheel_item_type    item,
   input  logic                        queue_full
);

   logic                               busy_ff;
   logic [sdik_pkg::WHEEL_W-1:0]       wheel_ff;
   logic signed [15:0]                 vx_ff, vy_ff, wz_ff;
   logic                               s1_valid_ff;
   logic [sdik_pkg::WHEEL_W-1:0]       s1_wheel_ff;
   logic signed [15:0]                 s1_vx_ff, s1_vy_ff;
   logic signed [31:0]                 s1_prod_x_ff, s1_prod_y_ff;
   logic                               accept, s1_advance, issue;
   logic signed [15:0]                 px, py;
   logic signed [32:0]                 cx_sum, cy_sum;
   logic signed [31:0]                 cx_val, cy_val, cx_fold, cy_fold;
   logic                               neg;

   assign req_full = busy_ff;
   assign accept = req_push && !busy_ff;
   assign s1_advance = s1_valid_ff && !queue_full;
   assign issue = busy_ff && (!s1_valid_ff || s1_advance);
   assign px = signed'(geometry[wheel_ff][15:0]);
   assign py = signed'(geometry[wheel_ff][31:16]);

   always_comb begin
      cx_sum = (33'(s1_vx_ff) <<< 13) - 33'(s1_prod_y_ff);
      cy_sum = (33'(s1_vy_ff) <<< 13) + 33'(s1_prod_x_ff);
      cx_val = cx_sum[31:0];
      cy_val = cy_sum[31:0];
      neg = (cx_val < 0) || ((cx_val == 0) && (cy_val < 0));
      cx_fold = neg ? -cx_val : cx_val;
      cy_fold = neg ? -cy_val : cy_val;
   end

   assign item_push = s1_valid_ff;
   assign item.wheel = s1_wheel_ff;
   assign item.neg = neg;
   assign item.cx = cx_fold[30:0];
   assign item.cy = cy_fold;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         wheel_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
            wheel_ff <= '0;
         end else if (issue) begin
            wheel_ff <= wheel_ff + 1'b1;
            if (wheel_ff == sdik_pkg::WHEEL_W'(sdik_pkg::WHEELS-1)) begin
               busy_ff <= 1'b0;
            end
         end
         if (issue) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         vx_ff <= req_linear_x;
         vy_ff <= req_linear_y;
         wz_ff <= req_angular_z;
      end
      if (issue) begin
         s1_wheel_ff <= wheel_ff;
         s1_vx_ff <= vx_ff;
         s1_vy_ff <= vy_ff;
         s1_prod_x_ff <= px * wz_ff;
         s1_prod_y_ff <= py * wz_ff;
      end
   end

endmodule

// ----- hdl/sdik_back.sv -----
// Back part: per wheel an iterative square root and CORDIC, a shared
// restoring divider for speed and limit scaling, and the result register.
// Depends on sdik_pkg.
module sdik_back #(
   parameter int CORDIC_STEPS = sdik_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sdik_pkg::geometry_type               geometry,
   input  logic [sdik_pkg::LIMIT_W-1:0]         max_speed,
   input  sdik_pkg::wheel_item_type             item,
   input  logic                                 item_empty,
   output logic                                 item_pop,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [sdik_pkg::SPEED_W-1:0]  rsp_wheel_speed_a,
   output logic signed [sdik_pkg::SPEED_W-1:0]  rsp_wheel_speed_b,
   output logic signed [sdik_pkg::SPEED_W-1:0]  rsp_wheel_speed_c,
   output logic signed [sdik_pkg::SPEED_W-1:0]  rsp_wheel_speed_d,
   output logic signed [sdik_pkg::ANGLE_W-1:0]  rsp_steer_angle_a,
   output logic signed [sdik_pkg::ANGLE_W-1:0]  rsp_steer_angle_b,
   output logic signed [sdik_pkg::ANGLE_W-1:0]  rsp_steer_angle_c,
   output logic signed [sdik_pkg::ANGLE_W-1:0]  rsp_steer_angle_d
);

   localparam int STEPS = (CORDIC_STEPS < sdik_pkg::ATAN_ENTRIES) ?
                          CORDIC_STEPS : sdik_pkg::ATAN_ENTRIES;
   localparam int ROOT_STEPS = 32;
   localparam int DIV_STEPS = 48;
   localparam int W = sdik_pkg::WHEELS;

   typedef enum logic [3:0] {
      ST_LOAD, ST_SQUARE, ST_ROOT, ST_PREPARE, ST_DIVIDE, ST_STORE,
      ST_SCALE, ST_SCALE_STORE, ST_DELIVER
   } state_type;

   state_type                            state_ff;
   logic [sdik_pkg::WHEEL_W-1:0]         wheel_ff, sidx_ff;
   logic                                 neg_ff, cx_zero_ff, cy_zero_ff, scaling_ff;
   logic [31:0]                          cy_abs_ff;
   logic [61:0]                          sq_ff;
   logic [15:0]                          rad_ff;
   logic [63:0]                          n_ff;
   logic [33:0]                          rem_ff;
   logic [31:0]                          root_ff;
   logic signed [34:0]                   x_ff, y_ff;
   logic signed [22:0]                   z_ff;
   logic [47:0]                          num_ff;
   logic [32:0]                          drem_ff;
   logic [31:0]                          den_ff;
   logic [5:0]                           step_ff;
   logic [31:0]                          raw_ff [W];
   logic [W-1:0]                         negs_ff;
   logic signed [sdik_pkg::ANGLE_W-1:0]  ang_ff [W];
   logic signed [sdik_pkg::SPEED_W-1:0]  speed_ff [W];
   logic [31:0]                          largest_ff;
   logic                                 rsp_valid_ff;
   logic signed [sdik_pkg::SPEED_W-1:0]  rsp_speed_ff [W];
   logic signed [sdik_pkg::ANGLE_W-1:0]  rsp_angle_ff [W];

   logic [33:0]                          rem_shift, trial;
   logic signed [34:0]                   dx, dy;
   logic signed [22:0]                   atan_v;
   logic [32:0]                          drem_shift;
   logic                                 qbit;
   logic signed [22:0]                   z_sel;
   logic signed [23:0]                   z_round;
   logic signed [15:0]                   r_q, r_clamp;
   logic signed [sdik_pkg::ANGLE_W-1:0]  heading;
   logic [31:0]                          raw_new, largest_new;
   logic [15:0]                          speed_mag;
   logic signed [sdik_pkg::SPEED_W-1:0]  speed_signed;
   logic                                 scale_need;

   assign item_pop = (state_ff == ST_LOAD) && !item_empty;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_wheel_speed_a = rsp_speed_ff[0];
   assign rsp_wheel_speed_b = rsp_speed_ff[1];
   assign rsp_wheel_speed_c = rsp_speed_ff[2];
   assign rsp_wheel_speed_d = rsp_speed_ff[3];
   assign rsp_steer_angle_a = rsp_angle_ff[0];
   assign rsp_steer_angle_b = rsp_angle_ff[1];
   assign rsp_steer_angle_c = rsp_angle_ff[2];
   assign rsp_steer_angle_d = rsp_angle_ff[3];

   always_comb begin
      rem_shift = {rem_ff[31:0], n_ff[63:62]};
      trial = {root_ff, 2'b01};
      dx = y_ff >>> step_ff[4:0];
      dy = x_ff >>> step_ff[4:0];
      atan_v = signed'(23'(sdik_pkg::atan_q20(step_ff[4:0])));
      drem_shift = {drem_ff[31:0], num_ff[47]};
      qbit = (drem_shift >= {1'b0, den_ff});
      z_sel = cx_zero_ff ? sdik_pkg::HALF_PI_Q20 : z_ff;
      z_round = 24'(z_sel) + 24'sd128;
      r_q = 16'(z_round >>> 8);
      if (r_q > sdik_pkg::ANGLE_LIMIT) begin
         r_clamp = sdik_pkg::ANGLE_LIMIT;
      end else if (r_q < -sdik_pkg::ANGLE_LIMIT) begin
         r_clamp = -sdik_pkg::ANGLE_LIMIT;
      end else begin
         r_clamp = r_q;
      end
      heading = cy_zero_ff ? '0 : r_clamp[sdik_pkg::ANGLE_W-1:0];
      if (rad_ff == '0) begin
         raw_new = (root_ff == '0) ? '0 : '1;
      end else begin
         raw_new = num_ff[31:0];
      end
      largest_new = (raw_new > largest_ff) ? raw_new : largest_ff;
      scale_need = (largest_ff > 32'(max_speed));
      speed_mag = (state_ff == ST_SCALE_STORE) ? num_ff[15:0] : raw_ff[sidx_ff][15:0];
      speed_signed = negs_ff[sidx_ff] ? -signed'({1'b0, speed_mag})
                                      : signed'({1'b0, speed_mag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_DELIVER) && (!rsp_valid_ff || rsp_pop)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (!item_empty) begin
                  wheel_ff <= item.wheel;
                  neg_ff <= item.neg;
                  cx_zero_ff <= (item.cx == '0);
                  cy_zero_ff <= (item.cy == '0);
                  cy_abs_ff <= (item.cy < 0) ? unsigned'(-item.cy) : unsigned'(item.cy);
                  sq_ff <= 62'(item.cx) * 62'(item.cx);
                  rad_ff <= geometry[item.wheel][47:32];
                  x_ff <= signed'(35'(item.cx));
                  y_ff <= 35'(item.cy);
                  z_ff <= '0;
                  if (item.wheel == '0) begin
                     largest_ff <= '0;
                  end
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: begin
               n_ff <= 64'(sq_ff) + (64'(cy_abs_ff) * 64'(cy_abs_ff));
               rem_ff <= '0;
               root_ff <= '0;
               step_ff <= '0;
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (rem_shift >= trial) begin
                  rem_ff <= rem_shift - trial;
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= rem_shift;
                  root_ff <= {root_ff[30:0], 1'b0};
               end
               n_ff <= {n_ff[61:0], 2'b00};
               if (step_ff < 6'(STEPS)) begin
                  if (y_ff > 0) begin
                     x_ff <= x_ff + dx;
                     y_ff <= y_ff - dy;
                     z_ff <= z_ff + atan_v;
                  end else begin
                     x_ff <= x_ff - dx;
                     y_ff <= y_ff + dy;
                     z_ff <= z_ff - atan_v;
                  end
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == 6'(ROOT_STEPS-1)) begin
                  state_ff <= ST_PREPARE;
               end
            end
            ST_PREPARE: begin
               num_ff <= 48'(root_ff) + 48'(rad_ff);
               den_ff <= 32'({rad_ff, 1'b0});
               drem_ff <= '0;
               step_ff <= '0;
               scaling_ff <= 1'b0;
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               drem_ff <= qbit ? drem_shift - {1'b0, den_ff} : drem_shift;
               num_ff <= {num_ff[46:0], qbit};
               step_ff <= step_ff + 1'b1;
               if (step_ff == 6'(DIV_STEPS-1)) begin
                  state_ff <= scaling_ff ? ST_SCALE_STORE : ST_STORE;
               end
            end
            ST_STORE: begin
               raw_ff[wheel_ff] <= raw_new;
               negs_ff[wheel_ff] <= neg_ff;
               ang_ff[wheel_ff] <= heading;
               largest_ff <= largest_new;
               if (wheel_ff == sdik_pkg::WHEEL_W'(W-1)) begin
                  sidx_ff <= '0;
                  state_ff <= ST_SCALE;
               end else begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_SCALE: begin
               if (scale_need) begin
                  num_ff <= 48'(raw_ff[sidx_ff] * 48'(max_speed)) + 48'(largest_ff >> 1);
                  den_ff <= largest_ff;
                  drem_ff <= '0;
                  step_ff <= '0;
                  scaling_ff <= 1'b1;
                  state_ff <= ST_DIVIDE;
               end else begin
                  speed_ff[sidx_ff] <= speed_signed;
                  sidx_ff <= sidx_ff + 1'b1;
                  if (sidx_ff == sdik_pkg::WHEEL_W'(W-1)) begin
                     state_ff <= ST_DELIVER;
                  end
               end
            end
            ST_SCALE_STORE: begin
               speed_ff[sidx_ff] <= speed_signed;
               sidx_ff <= sidx_ff + 1'b1;
               state_ff <= (sidx_ff == sdik_pkg::WHEEL_W'(W-1)) ? ST_DELIVER : ST_SCALE;
            end
            ST_DELIVER: begin
               if (!rsp_valid_ff || rsp_pop) begin
                  rsp_speed_ff <= speed_ff;
                  rsp_angle_ff <= ang_ff;
                  state_ff <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

endmodule

// ----- hdl/swerve_drive_inverse_kinematics.sv -----
// Top level of the swerve drive inverse kinematics block: configuration
// registers, front part, wheel queue and back part.
// Depends on sdik_pkg, sdik_front, sdik_fifo and sdik_back.
//
// A command (linear_x, linear_y, angular_z) is transferred on the req_ side
// when req_push is high and req_full is low. The block answers each command
// with one result: four signed wheel speeds and four steering angles, shown
// on the rsp_ side while rsp_empty is low and taken when rsp_pop is high.
// The front part turns a command into four wheel records in turn, then
// takes the next; the queue holds QUEUE_DEPTH records (four by default).
// The back part handles one wheel at a time: the square root and CORDIC,
// then the speed division. After the last wheel it scales each speed,
// through the divider when the speed limit applies, and loads the result
// register. It takes no new record until it is done with the last one.
// If rsp_pop stays low, the back part finishes the next command and waits
// with it; the queue then fills and req_full rises.
// Reset clears all control state and restores the default geometry and limit.
// Registers are written on the csr_ side, which is always ready; the user
// must write them only while the block is idle, which the block does not enforce.
module swerve_drive_inverse_kinematics #(
   parameter int CORDIC_STEPS = sdik_pkg::CORDIC_STEPS_DEFAULT,
   parameter int QUEUE_DEPTH = sdik_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic signed [sdik_pkg::CMD_W-1:0]      req_linear_x,
   input  logic signed [sdik_pkg::CMD_W-1:0]      req_linear_y,
   input  logic signed [sdik_pkg::CMD_W-1:0]      req_angular_z,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic signed [sdik_pkg::SPEED_W-1:0]    rsp_wheel_speed_a,
   output logic signed [sdik_pkg::SPEED_W-1:0]    rsp_wheel_speed_b,
   output logic signed [sdik_pkg::SPEED_W-1:0]    rsp_wheel_speed_c,
   output logic signed [sdik_pkg::SPEED_W-1:0]    rsp_wheel_speed_d,
   output logic signed [sdik_pkg::ANGLE_W-1:0]    rsp_steer_angle_a,
   output logic signed [sdik_pkg::ANGLE_W-1:0]    rsp_steer_angle_b,
   output logic signed [sdik_pkg::ANGLE_W-1:0]    rsp_steer_angle_c,
   output logic signed [sdik_pkg::ANGLE_W-1:0]    rsp_steer_angle_d,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sdik_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [sdik_pkg::GEO_W-1:0]             csr_wdata
);

   sdik_pkg::geometry_type             geometry_ff;
   logic [sdik_pkg::LIMIT_W-1:0]       max_speed_ff;
   sdik_pkg::wheel_item_type           front_item, back_item;
   logic                               item_push, queue_full, item_pop, item_empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         geometry_ff[0] <= sdik_pkg::GEOMETRY_A_RESET;
         geometry_ff[1] <= sdik_pkg::GEOMETRY_B_RESET;
         geometry_ff[2] <= sdik_pkg::GEOMETRY_C_RESET;
         geometry_ff[3] <= sdik_pkg::GEOMETRY_D_RESET;
         max_speed_ff <= sdik_pkg::MAX_SPEED_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            sdik_pkg::CSR_GEOMETRY_A: geometry_ff[0] <= csr_wdata;
            sdik_pkg::CSR_GEOMETRY_B: geometry_ff[1] <= csr_wdata;
            sdik_pkg::CSR_GEOMETRY_C: geometry_ff[2] <= csr_wdata;
            sdik_pkg::CSR_GEOMETRY_D: geometry_ff[3] <= csr_wdata;
            sdik_pkg::CSR_MAX_SPEED:  max_speed_ff <= csr_wdata[sdik_pkg::LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   sdik_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_linear_x  (req_linear_x),
      .req_linear_y  (req_linear_y),
      .req_angular_z (req_angular_z),
      .geometry      (geometry_ff),
      .item_push     (item_push),
      .item          (front_item),
      .queue_full    (queue_full)
   );

   sdik_fifo #(
      .WIDTH ($bits(sdik_pkg::wheel_item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_push),
      .push_data (front_item),
      .full      (queue_full),
      .pop       (item_pop),
      .pop_data  (back_item),
      .empty     (item_empty)
   );

   sdik_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .geometry          (geometry_ff),
      .max_speed         (max_speed_ff),
      .item              (back_item),
      .item_empty        (item_empty),
      .item_pop          (item_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_wheel_speed_a (rsp_wheel_speed_a),
      .rsp_wheel_speed_b (rsp_wheel_speed_b),
      .rsp_wheel_speed_c (rsp_wheel_speed_c),
      .rsp_wheel_speed_d (rsp_wheel_speed_d),
      .rsp_steer_angle_a (rsp_steer_angle_a),
      .rsp_steer_angle_b (rsp_steer_angle_b),
      .rsp_steer_angle_c (rsp_steer_angle_c),
      .rsp_steer_angle_d (rsp_steer_angle_d)
   );

endmodule
